/* rtl/wlf_pkg.sv */
// wlf_pkg: shared types and constants of the windowed line fit block
// no dependencies; imported by the arithmetic unit and the top level
package wlf_pkg;

    localparam int          WINDOW_DEPTH_DEF = 16;
    localparam logic [31:0] MAX_DIFF_RST     = 32'd6554;
    localparam int          FRAC_BITS        = 16;
    localparam logic [16:0] R2_ONE           = 17'd65536;
    localparam int          MIN_FIT_SAMPLES  = 2;

    typedef enum logic [1:0] {
        CMD_ADD   = 2'd0,
        CMD_REFIT = 2'd1,
        CMD_QUERY = 2'd2,
        CMD_CLEAR = 2'd3
    } cmd_t;

    typedef enum logic {
        MDU_MUL = 1'b0,
        MDU_DIV = 1'b1
    } mdu_op_t;

    typedef struct packed {
        logic    start;
        mdu_op_t op;
    } mdu_ctl_t;

endpackage

/* rtl/wlf_if.sv */
// wlf_if: valid/ready channel interfaces for requests, results and config writes
// no dependencies
interface wlf_cmd_if ();
    logic               valid;
    logic               ready;
    logic [1:0]         command;
    logic signed [31:0] sample_x;
    logic signed [31:0] sample_y;

    modport source (output valid, command, sample_x, sample_y, input ready);
    modport sink   (input valid, command, sample_x, sample_y, output ready);
endinterface

interface wlf_res_if ();
    logic               valid;
    logic               ready;
    logic signed [31:0] slope;
    logic signed [31:0] intercept;
    logic [16:0]        r_squared;
    logic signed [31:0] best_y;
    logic               from_fit;
    logic               fit_degenerate;
    logic [4:0]         sample_count;

    modport source (output valid, slope, intercept, r_squared, best_y, from_fit,
                    fit_degenerate, sample_count, input ready);
    modport sink   (input valid, slope, intercept, r_squared, best_y, from_fit,
                    fit_degenerate, sample_count, output ready);
endinterface

interface wlf_cfg_if ();
    logic        valid;
    logic        ready;
    logic [31:0] data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

/* rtl/wlf_ram.sv */
// wlf_ram: generic single write port, single read port ram with registered read
// no dependencies
module wlf_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16
) (
    input  logic                             clk,
    input  logic                             we,
    input  logic [$clog2(DEPTH)-1:0]         waddr,
    input  logic [WIDTH-1:0]                 wdata,
    input  logic [$clog2(DEPTH)-1:0]         raddr,
    output logic [WIDTH-1:0]                 rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/wlf_mdu.sv */
// wlf_mdu: shared signed shift-add multiplier and restoring divider, one bit a cycle
// depends on wlf_pkg
module wlf_mdu import wlf_pkg::*; #(
    parameter int W = 164
) (
    input  logic                clk,
    input  logic                rst_n,
    input  mdu_ctl_t            ctl,
    input  logic signed [W-1:0] a,
    input  logic signed [W-1:0] b,
    output logic                done,
    output logic signed [W-1:0] result
);

    localparam int CNTW = $clog2(W + 1);

    typedef enum logic [2:0] {
        M_IDLE = 3'b001,
        M_RUN  = 3'b010,
        M_FIN  = 3'b100
    } mstate_t;

    mstate_t             state_reg, state_next;
    logic                done_reg, done_next;
    mdu_op_t             op_reg, op_next;
    logic                neg_reg, neg_next;
    logic [W-1:0]        ua_reg, ua_next;
    logic [W-1:0]        ub_reg, ub_next;
    logic [W-1:0]        acc_reg, acc_next;
    logic [W-1:0]        rem_reg, rem_next;
    logic [CNTW-1:0]     cnt_reg, cnt_next;
    logic signed [W-1:0] result_reg, result_next;

    logic [W-1:0] abs_a, abs_b, rem_sh;
    logic         ge;

    always_comb
    begin
        abs_a  = a[W-1] ? W'(-a) : W'(a);
        abs_b  = b[W-1] ? W'(-b) : W'(b);
        rem_sh = {rem_reg[W-2:0], ua_reg[W-1]};
        ge     = (rem_sh >= ub_reg);

        state_next  = state_reg;
        done_next   = 1'b0;
        op_next     = op_reg;
        neg_next    = neg_reg;
        ua_next     = ua_reg;
        ub_next     = ub_reg;
        acc_next    = acc_reg;
        rem_next    = rem_reg;
        cnt_next    = cnt_reg;
        result_next = result_reg;

        case (state_reg)
            M_IDLE:
            begin
                if (ctl.start)
                begin
                    op_next    = ctl.op;
                    neg_next   = a[W-1] ^ b[W-1];
                    ua_next    = abs_a;
                    ub_next    = abs_b;
                    acc_next   = '0;
                    rem_next   = '0;
                    cnt_next   = '0;
                    state_next = M_RUN;
                end
            end
            M_RUN:
            begin
                if (op_reg == MDU_MUL)
                begin
                    // stop as soon as the multiplier bits run out
                    if (ub_reg == '0)
                    begin
                        state_next = M_FIN;
                    end
                    else
                    begin
                        if (ub_reg[0])
                        begin
                            acc_next = acc_reg + ua_reg;
                        end
                        ua_next = ua_reg << 1;
                        ub_next = ub_reg >> 1;
                    end
                end
                else
                begin
                    rem_next = ge ? (rem_sh - ub_reg) : rem_sh;
                    acc_next = {acc_reg[W-2:0], ge};
                    ua_next  = ua_reg << 1;
                    cnt_next = cnt_reg + 1'b1;
                    if (cnt_reg == CNTW'(W - 1))
                    begin
                        state_next = M_FIN;
                    end
                end
            end
            M_FIN:
            begin
                result_next = neg_reg ? $signed(-acc_reg) : $signed(acc_reg);
                done_next   = 1'b1;
                state_next  = M_IDLE;
            end
            default:
            begin
                state_next = M_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= M_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg     <= op_next;
        neg_reg    <= neg_next;
        ua_reg     <= ua_next;
        ub_reg     <= ub_next;
        acc_reg    <= acc_next;
        rem_reg    <= rem_next;
        cnt_reg    <= cnt_next;
        result_reg <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

/* rtl/windowed_linear_fit_outlier_filter_core.sv */
// windowed_linear_fit_outlier_filter_core: top level of the windowed line fit filter
// depends on wlf_pkg, wlf_if, wlf_ram and wlf_mdu
//
// keeps the last WINDOW_DEPTH (x,y) samples (signed q16.16) in a ram and serves four
// requests: add a sample (newest overwrites oldest once the window is full), refit the
// least-squares line (slope, intercept, r squared in q1.16), query a best y at a given x,
// and clear the window; every request yields exactly one result carrying the current
// fit, the query answer and the sample count. one request is worked on at a time and
// cmd.ready is high only while the sequencer idles; a finished result waits in an
// output register, so the next request is taken while it waits. all wide arithmetic
// goes through one shared unit (wlf_mdu) that handles one bit per cycle, on operands of
// W = 144 + 4 * clog2(WINDOW_DEPTH + 1) bits (164 at the default depth); a multiply ends
// once no set bit of its second operand is left, a divide runs through all W bits, and
// the sequencer waits in each such step until the unit is done. add, clear and a refit
// with fewer than two samples need no arithmetic; a query takes two multiplies; a refit
// reads each sample and takes three multiplies per sample to build the sums, then up to
// ten more multiplies and up to three divides. no clearing pass is needed after reset.
module windowed_linear_fit_outlier_filter_core import wlf_pkg::*; #(
    parameter int WINDOW_DEPTH = WINDOW_DEPTH_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    wlf_cmd_if.sink   cmd,
    wlf_res_if.source res,
    wlf_cfg_if.sink   cfg
);

    localparam int AW = $clog2(WINDOW_DEPTH);
    localparam int CW = $clog2(WINDOW_DEPTH + 1);
    // wide enough for dxy^2 * 2^16 at full window plus sign
    localparam int W  = 144 + 4 * CW;

    typedef enum logic [21:0] {
        S_IDLE    = 22'h000001,
        S_ACC_RD  = 22'h000002,
        S_ACC_LD  = 22'h000004,
        S_ACC_XX  = 22'h000008,
        S_ACC_XY  = 22'h000010,
        S_ACC_YY  = 22'h000020,
        S_NXX     = 22'h000040,
        S_SXSX    = 22'h000080,
        S_NXY     = 22'h000100,
        S_SXSY    = 22'h000200,
        S_NYY     = 22'h000400,
        S_SYSY    = 22'h000800,
        S_SLOPE   = 22'h001000,
        S_INT_A   = 22'h002000,
        S_INT_B   = 22'h004000,
        S_INT_DIV = 22'h008000,
        S_R2_A    = 22'h010000,
        S_R2_B    = 22'h020000,
        S_R2_DIV  = 22'h040000,
        S_Q_FIT   = 22'h080000,
        S_Q_TOL   = 22'h100000,
        S_RESP    = 22'h200000
    } state_t;

    function automatic logic signed [31:0] sat32(input logic signed [W-1:0] v);
        logic fits;
        fits = (v[W-1:31] == '0) || (v[W-1:31] == '1);
        if (fits)
        begin
            return v[31:0];
        end
        return v[W-1] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    endfunction

    // control state
    state_t             state_reg, state_next;
    logic               launched_reg, launched_next;
    logic [CW-1:0]      count_reg, count_next;
    logic [AW-1:0]      slot_reg, slot_next;
    logic [CW-1:0]      idx_reg, idx_next;
    logic               res_valid_reg, res_valid_next;
    logic [31:0]        maxd_reg, maxd_next;
    logic signed [31:0] fit_slope_reg, fit_slope_next;
    logic signed [31:0] fit_intercept_reg, fit_intercept_next;
    logic [16:0]        fit_r2_reg, fit_r2_next;
    logic               deg_reg, deg_next;

    // datapath
    logic signed [31:0] x_reg, x_next;
    logic signed [31:0] y_reg, y_next;
    logic signed [W-1:0] sx_reg, sx_next, sy_reg, sy_next;
    logic signed [W-1:0] sxx_reg, sxx_next, sxy_reg, sxy_next, syy_reg, syy_next;
    logic signed [W-1:0] dx_reg, dx_next, dxy_reg, dxy_next, dy_reg, dy_next;
    logic signed [W-1:0] tmp_reg, tmp_next;
    logic signed [31:0] pend_best_reg, pend_best_next;
    logic               pend_from_reg, pend_from_next;

    // result register
    logic signed [31:0] out_slope_reg, out_slope_next;
    logic signed [31:0] out_intercept_reg, out_intercept_next;
    logic [16:0]        out_r2_reg, out_r2_next;
    logic signed [31:0] out_best_reg, out_best_next;
    logic               out_from_reg, out_from_next;
    logic               out_deg_reg, out_deg_next;
    logic [4:0]         out_count_reg, out_count_next;

    // sample store and shared unit
    logic                ram_we;
    logic [63:0]         ram_wdata, ram_rdata;
    mdu_ctl_t            mdu_ctl;
    logic signed [W-1:0] mdu_a, mdu_b, mdu_res;
    logic                mdu_done;
    logic                is_op;

    logic                cmd_acc;
    logic [CW+4:0]       count_wide;
    logic signed [W-1:0] fit_abs, diff, lhs;
    logic                tol_ok;

    wlf_ram #(
        .WIDTH (64),
        .DEPTH (WINDOW_DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (slot_reg),
        .wdata (ram_wdata),
        .raddr (idx_reg[AW-1:0]),
        .rdata (ram_rdata)
    );

    wlf_mdu #(
        .W (W)
    ) u_mdu (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctl    (mdu_ctl),
        .a      (mdu_a),
        .b      (mdu_b),
        .done   (mdu_done),
        .result (mdu_res)
    );

    assign cmd.ready = (state_reg == S_IDLE);
    assign cmd_acc   = cmd.valid && cmd.ready;
    assign cfg.ready = 1'b1;
    assign ram_wdata = {cmd.sample_x, cmd.sample_y};

    // operand selection for the shared unit, one step per sequencer state
    always_comb
    begin
        is_op  = 1'b1;
        mdu_a  = '0;
        mdu_b  = '0;
        mdu_ctl.op = MDU_MUL;
        case (state_reg)
            S_ACC_XX:  begin mdu_a = W'(x_reg);   mdu_b = W'(x_reg);     end
            S_ACC_XY:  begin mdu_a = W'(x_reg);   mdu_b = W'(y_reg);     end
            S_ACC_YY:  begin mdu_a = W'(y_reg);   mdu_b = W'(y_reg);     end
            S_NXX:     begin mdu_a = sxx_reg;     mdu_b = W'(count_reg); end
            S_SXSX:    begin mdu_a = sx_reg;      mdu_b = sx_reg;        end
            S_NXY:     begin mdu_a = sxy_reg;     mdu_b = W'(count_reg); end
            S_SXSY:    begin mdu_a = sx_reg;      mdu_b = sy_reg;        end
            S_NYY:     begin mdu_a = syy_reg;     mdu_b = W'(count_reg); end
            S_SYSY:    begin mdu_a = sy_reg;      mdu_b = sy_reg;        end
            S_SLOPE:
            begin
                mdu_a      = dxy_reg <<< FRAC_BITS;
                mdu_b      = dx_reg;
                mdu_ctl.op = MDU_DIV;
            end
            S_INT_A:   begin mdu_a = sxx_reg;     mdu_b = sy_reg;        end
            S_INT_B:   begin mdu_a = sxy_reg;     mdu_b = sx_reg;        end
            S_INT_DIV:
            begin
                mdu_a      = tmp_reg;
                mdu_b      = dx_reg;
                mdu_ctl.op = MDU_DIV;
            end
            S_R2_A:    begin mdu_a = dxy_reg;     mdu_b = dxy_reg;       end
            S_R2_B:    begin mdu_a = dx_reg;      mdu_b = dy_reg;        end
            S_R2_DIV:
            begin
                mdu_a      = tmp_reg;
                mdu_b      = dx_reg;
                mdu_ctl.op = MDU_DIV;
            end
            S_Q_FIT:   begin mdu_a = W'(fit_slope_reg); mdu_b = W'(x_reg); end
            S_Q_TOL:   begin mdu_a = fit_abs; mdu_b = {{(W-32){1'b0}}, maxd_reg}; end
            default:   is_op = 1'b0;
        endcase
        mdu_ctl.start = is_op && !launched_reg;
    end

    // outlier test on the exact fitted value held in tmp_reg
    always_comb
    begin
        fit_abs = tmp_reg[W-1] ? -tmp_reg : tmp_reg;
        diff    = tmp_reg - W'(y_reg);
        lhs     = (diff[W-1] ? -diff : diff) <<< FRAC_BITS;
        tol_ok  = ($unsigned(lhs) <= $unsigned(mdu_res));
    end

    always_comb
    begin
        state_next         = state_reg;
        launched_next      = launched_reg;
        count_next         = count_reg;
        slot_next          = slot_reg;
        idx_next           = idx_reg;
        res_valid_next     = res_valid_reg;
        maxd_next          = maxd_reg;
        fit_slope_next     = fit_slope_reg;
        fit_intercept_next = fit_intercept_reg;
        fit_r2_next        = fit_r2_reg;
        deg_next           = deg_reg;
        x_next             = x_reg;
        y_next             = y_reg;
        sx_next            = sx_reg;
        sy_next            = sy_reg;
        sxx_next           = sxx_reg;
        sxy_next           = sxy_reg;
        syy_next           = syy_reg;
        dx_next            = dx_reg;
        dxy_next           = dxy_reg;
        dy_next            = dy_reg;
        tmp_next           = tmp_reg;
        pend_best_next     = pend_best_reg;
        pend_from_next     = pend_from_reg;
        out_slope_next     = out_slope_reg;
        out_intercept_next = out_intercept_reg;
        out_r2_next        = out_r2_reg;
        out_best_next      = out_best_reg;
        out_from_next      = out_from_reg;
        out_deg_next       = out_deg_reg;
        out_count_next     = out_count_reg;
        ram_we             = 1'b0;
        count_wide         = (CW+5)'(count_reg);

        if (cfg.valid)
        begin
            maxd_next = cfg.data;
        end

        // shared unit handshake: launch once, clear on completion
        if (mdu_ctl.start)
        begin
            launched_next = 1'b1;
        end
        if (mdu_done)
        begin
            launched_next = 1'b0;
        end

        if (res.ready)
        begin
            res_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (cmd_acc)
                begin
                    pend_best_next = '0;
                    pend_from_next = 1'b0;
                    x_next         = cmd.sample_x;
                    y_next         = cmd.sample_y;
                    state_next     = S_RESP;
                    case (cmd_t'(cmd.command))
                        CMD_ADD:
                        begin
                            ram_we    = 1'b1;
                            slot_next = (slot_reg == AW'(WINDOW_DEPTH - 1)) ? '0
                                                                           : slot_reg + 1'b1;
                            if (count_reg < CW'(WINDOW_DEPTH))
                            begin
                                count_next = count_reg + 1'b1;
                            end
                        end
                        CMD_REFIT:
                        begin
                            // too few samples leaves the fit untouched
                            if (count_reg >= CW'(MIN_FIT_SAMPLES))
                            begin
                                sx_next    = '0;
                                sy_next    = '0;
                                sxx_next   = '0;
                                sxy_next   = '0;
                                syy_next   = '0;
                                idx_next   = '0;
                                state_next = S_ACC_RD;
                            end
                        end
                        CMD_QUERY:
                        begin
                            state_next = S_Q_FIT;
                        end
                        CMD_CLEAR:
                        begin
                            count_next = '0;
                            slot_next  = '0;
                        end
                        default:
                        begin
                            state_next = S_RESP;
                        end
                    endcase
                end
            end
            S_ACC_RD:
            begin
                // ram read address is idx_reg, data shows up next cycle
                state_next = S_ACC_LD;
            end
            S_ACC_LD:
            begin
                x_next     = ram_rdata[63:32];
                y_next     = ram_rdata[31:0];
                sx_next    = sx_reg + W'($signed(ram_rdata[63:32]));
                sy_next    = sy_reg + W'($signed(ram_rdata[31:0]));
                state_next = S_ACC_XX;
            end
            S_ACC_XX:
            begin
                if (mdu_done)
                begin
                    sxx_next   = sxx_reg + mdu_res;
                    state_next = S_ACC_XY;
                end
            end
            S_ACC_XY:
            begin
                if (mdu_done)
                begin
                    sxy_next   = sxy_reg + mdu_res;
                    state_next = S_ACC_YY;
                end
            end
            S_ACC_YY:
            begin
                if (mdu_done)
                begin
                    syy_next = syy_reg + mdu_res;
                    idx_next = idx_reg + 1'b1;
                    state_next = (idx_reg + 1'b1 == count_reg) ? S_NXX : S_ACC_RD;
                end
            end
            S_NXX:
            begin
                if (mdu_done)
                begin
                    tmp_next   = mdu_res;
                    state_next = S_SXSX;
                end
            end
            S_SXSX:
            begin
                if (mdu_done)
                begin
                    dx_next    = tmp_reg - mdu_res;
                    state_next = S_NXY;
                end
            end
            S_NXY:
            begin
                if (mdu_done)
                begin
                    tmp_next   = mdu_res;
                    state_next = S_SXSY;
                end
            end
            S_SXSY:
            begin
                if (mdu_done)
                begin
                    dxy_next   = tmp_reg - mdu_res;
                    state_next = S_NYY;
                end
            end
            S_NYY:
            begin
                if (mdu_done)
                begin
                    tmp_next   = mdu_res;
                    state_next = S_SYSY;
                end
            end
            S_SYSY:
            begin
                if (mdu_done)
                begin
                    dy_next = tmp_reg - mdu_res;
                    if (dx_reg == '0)
                    begin
                        // all x equal: no line, report a zero fit
                        fit_slope_next     = '0;
                        fit_intercept_next = '0;
                        fit_r2_next        = '0;
                        deg_next           = 1'b1;
                        state_next         = S_RESP;
                    end
                    else
                    begin
                        deg_next   = 1'b0;
                        state_next = S_SLOPE;
                    end
                end
            end
            S_SLOPE:
            begin
                if (mdu_done)
                begin
                    fit_slope_next = sat32(mdu_res);
                    state_next     = S_INT_A;
                end
            end
            S_INT_A:
            begin
                if (mdu_done)
                begin
                    tmp_next   = mdu_res;
                    state_next = S_INT_B;
                end
            end
            S_INT_B:
            begin
                if (mdu_done)
                begin
                    tmp_next   = tmp_reg - mdu_res;
                    state_next = S_INT_DIV;
                end
            end
            S_INT_DIV:
            begin
                if (mdu_done)
                begin
                    fit_intercept_next = sat32(mdu_res);
                    if (dy_reg[W-1] || (dy_reg == '0))
                    begin
                        // flat y: no variance to explain
                        fit_r2_next = '0;
                        state_next  = S_RESP;
                    end
                    else
                    begin
                        state_next = S_R2_A;
                    end
                end
            end
            S_R2_A:
            begin
                if (mdu_done)
                begin
                    tmp_next   = mdu_res <<< FRAC_BITS;
                    state_next = S_R2_B;
                end
            end
            S_R2_B:
            begin
                if (mdu_done)
                begin
                    // denominator dx * dy reuses dx_reg
                    dx_next    = mdu_res;
                    state_next = S_R2_DIV;
                end
            end
            S_R2_DIV:
            begin
                if (mdu_done)
                begin
                    fit_r2_next = (mdu_res > W'(R2_ONE)) ? R2_ONE : mdu_res[16:0];
                    state_next  = S_RESP;
                end
            end
            S_Q_FIT:
            begin
                if (mdu_done)
                begin
                    // floor of slope * x / 2^16 plus intercept, kept exact
                    tmp_next   = (mdu_res >>> FRAC_BITS) + W'(fit_intercept_reg);
                    state_next = S_Q_TOL;
                end
            end
            S_Q_TOL:
            begin
                if (mdu_done)
                begin
                    pend_best_next = tol_ok ? y_reg : sat32(tmp_reg);
                    pend_from_next = !tol_ok;
                    state_next     = S_RESP;
                end
            end
            S_RESP:
            begin
                if (!res_valid_reg || res.ready)
                begin
                    out_slope_next     = fit_slope_reg;
                    out_intercept_next = fit_intercept_reg;
                    out_r2_next        = fit_r2_reg;
                    out_best_next      = pend_best_reg;
                    out_from_next      = pend_from_reg;
                    out_deg_next       = deg_reg;
                    out_count_next     = count_wide[4:0];
                    res_valid_next     = 1'b1;
                    state_next         = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= S_IDLE;
            launched_reg      <= 1'b0;
            count_reg         <= '0;
            slot_reg          <= '0;
            idx_reg           <= '0;
            res_valid_reg     <= 1'b0;
            maxd_reg          <= MAX_DIFF_RST;
            fit_slope_reg     <= '0;
            fit_intercept_reg <= '0;
            fit_r2_reg        <= '0;
            deg_reg           <= 1'b0;
        end
        else
        begin
            state_reg         <= state_next;
            launched_reg      <= launched_next;
            count_reg         <= count_next;
            slot_reg          <= slot_next;
            idx_reg           <= idx_next;
            res_valid_reg     <= res_valid_next;
            maxd_reg          <= maxd_next;
            fit_slope_reg     <= fit_slope_next;
            fit_intercept_reg <= fit_intercept_next;
            fit_r2_reg        <= fit_r2_next;
            deg_reg           <= deg_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg             <= x_next;
        y_reg             <= y_next;
        sx_reg            <= sx_next;
        sy_reg            <= sy_next;
        sxx_reg           <= sxx_next;
        sxy_reg           <= sxy_next;
        syy_reg           <= syy_next;
        dx_reg            <= dx_next;
        dxy_reg           <= dxy_next;
        dy_reg            <= dy_next;
        tmp_reg           <= tmp_next;
        pend_best_reg     <= pend_best_next;
        pend_from_reg     <= pend_from_next;
        out_slope_reg     <= out_slope_next;
        out_intercept_reg <= out_intercept_next;
        out_r2_reg        <= out_r2_next;
        out_best_reg      <= out_best_next;
        out_from_reg      <= out_from_next;
        out_deg_reg       <= out_deg_next;
        out_count_reg     <= out_count_next;
    end

    assign res.valid          = res_valid_reg;
    assign res.slope          = out_slope_reg;
    assign res.intercept      = out_intercept_reg;
    assign res.r_squared      = out_r2_reg;
    assign res.best_y         = out_best_reg;
    assign res.from_fit       = out_from_reg;
    assign res.fit_degenerate = out_deg_reg;
    assign res.sample_count   = out_count_reg;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(WINDOW_DEPTH))
        else $error("sample count above window depth");

    a_add_count: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_acc && (cmd.command == CMD_ADD) && (count_reg < CW'(WINDOW_DEPTH)))
        |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("add request did not grow the window");

    a_done_launched: assert property (@(posedge clk) disable iff (!rst_n)
        mdu_done |-> launched_reg)
        else $error("arithmetic unit finished without a launched step");

    a_r2_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fit_r2_reg <= R2_ONE)
        else $error("r squared above one");

    a_degenerate_zero: assert property (@(posedge clk) disable iff (!rst_n)
        deg_reg |-> ((fit_slope_reg == '0) && (fit_intercept_reg == '0)
                     && (fit_r2_reg == '0)))
        else $error("degenerate fit with nonzero coefficients");
`endif

endmodule

/* dv/wlf_tb_if.sv */
`timescale 1ns / 1ps
// wlf_tb_if: testbench copy point for the valid/ready channel interfaces
// depends on wlf_pkg; the tb instantiates rtl/wlf_if.sv (wlf_cmd_if, wlf_res_if, wlf_cfg_if) as is
// holds the request item and expected result types used by the top level
package wlf_tb_types;
    import wlf_pkg::*;

    typedef struct {
        cmd_t               op;
        logic signed [31:0] x;
        logic signed [31:0] y;
    } fit_req_t;

    typedef struct {
        logic signed [31:0] slope;
        logic signed [31:0] intercept;
        logic [16:0]        r_squared;
        logic signed [31:0] best_y;
        logic               from_fit;
        logic               fit_degenerate;
        logic [4:0]         sample_count;
    } fit_result_t;
endpackage

/* dv/tb_windowed_linear_fit_outlier_filter_core.sv */
`timescale 1ns / 1ps
// tb_windowed_linear_fit_outlier_filter_core: self-checking bench for the windowed line fit
// depends on wlf_pkg, wlf_if, wlf_tb_types and the core; predicts every result in wide
// integer arithmetic and checks it field by field, with random stalls on both channels
module tb_windowed_linear_fit_outlier_filter_core;
    import wlf_pkg::*;
    import wlf_tb_types::*;

    typedef logic signed [255:0] wide_t;

    localparam int  DEPTH     = 16;
    localparam int  CYCLE_CAP = 4000000;

    logic clk;
    logic rst_n;

    wlf_cmd_if cmd_ch ();
    wlf_res_if res_ch ();
    wlf_cfg_if cfg_ch ();

    windowed_linear_fit_outlier_filter_core dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_ch.sink),
        .res   (res_ch.source),
        .cfg   (cfg_ch.sink)
    );

    // 8 ns clock
    always
    begin
        clk = 1'b1;
        #4;
        clk = 1'b0;
        #4;
    end

    // pending requests and expected results
    fit_req_t    req_q[$];
    fit_result_t fit_exp_q[$];

    // predictor state
    logic signed [31:0] win_x[DEPTH];
    logic signed [31:0] win_y[DEPTH];
    int unsigned        wr_slot;
    int unsigned        n_valid;
    logic signed [31:0] cur_slope;
    logic signed [31:0] cur_icpt;
    logic [16:0]        cur_r2;
    logic               cur_degen;
    logic [31:0]        max_diff;

    // bookkeeping
    int  n_errors;
    int  n_results;
    int  n_from_fit;
    int  n_degen_fits;
    int  n_cfg_writes;
    int  cycles;
    bit  cmd_took;
    bit  calm;
    int  cmd_gap;
    int  res_gap;

    function automatic logic signed [31:0] clip_wide(wide_t v);
        if (v[255:31] == '0 || v[255:31] == '1)
            return v[31:0];
        return v[255] ? 32'sh80000000 : 32'sh7fffffff;
    endfunction

    function automatic logic signed [31:0] clip_long(longint v);
        if (v[63:31] == '0 || v[63:31] == '1)
            return v[31:0];
        return v[63] ? 32'sh80000000 : 32'sh7fffffff;
    endfunction

    // least-squares refit over the valid part of the window
    task automatic refit_line();
        wide_t sx, sy, sxx, sxy, syy, nw, dx, dxy, dy, q;
        if (n_valid < MIN_FIT_SAMPLES)
            return;
        sx = '0; sy = '0; sxx = '0; sxy = '0; syy = '0;
        for (int i = 0; i < n_valid; i++)
        begin
            sx  += wide_t'(win_x[i]);
            sy  += wide_t'(win_y[i]);
            sxx += wide_t'(longint'(win_x[i]) * longint'(win_x[i]));
            sxy += wide_t'(longint'(win_x[i]) * longint'(win_y[i]));
            syy += wide_t'(longint'(win_y[i]) * longint'(win_y[i]));
        end
        nw  = wide_t'(n_valid);
        dx  = nw * sxx - sx * sx;
        dxy = nw * sxy - sx * sy;
        dy  = nw * syy - sy * sy;
        // all x equal: no line
        if (dx == 0)
        begin
            cur_slope = '0;
            cur_icpt  = '0;
            cur_r2    = '0;
            cur_degen = 1'b1;
            n_degen_fits++;
            return;
        end
        cur_degen = 1'b0;
        cur_slope = clip_wide((dxy * 65536) / dx);
        cur_icpt  = clip_wide((sy * sxx - sx * sxy) / dx);
        // flat y gives no defined fit quality
        if (dy <= 0)
            cur_r2 = '0;
        else
        begin
            q = (dxy * dxy * 65536) / (dx * dy);
            cur_r2 = (q > 65536) ? R2_ONE : q[16:0];
        end
    endtask

    // works out the result of one accepted request and updates the state
    task automatic predict_fit(fit_req_t r);
        fit_result_t e;
        longint      prod, fitted, dev, mag;
        logic [127:0] lhs, rhs;
        e.best_y   = '0;
        e.from_fit = 1'b0;
        case (r.op)
            CMD_ADD:
            begin
                win_x[wr_slot] = r.x;
                win_y[wr_slot] = r.y;
                wr_slot = (wr_slot + 1) % DEPTH;
                if (n_valid < DEPTH)
                    n_valid++;
            end
            CMD_REFIT:
                refit_line();
            CMD_QUERY:
            begin
                prod   = longint'(cur_slope) * longint'(r.x);
                fitted = (prod >>> FRAC_BITS) + longint'(cur_icpt);
                dev    = fitted - longint'(r.y);
                dev    = dev < 0 ? -dev : dev;
                mag    = fitted < 0 ? -fitted : fitted;
                lhs    = {64'd0, 64'(dev)} << FRAC_BITS;
                rhs    = {96'd0, max_diff} * {64'd0, 64'(mag)};
                // within the allowed relative deviation keeps the measurement
                if (lhs <= rhs)
                    e.best_y = r.y;
                else
                begin
                    e.best_y   = clip_long(fitted);
                    e.from_fit = 1'b1;
                    n_from_fit++;
                end
            end
            default:
            begin
                n_valid = 0;
                wr_slot = 0;
            end
        endcase
        e.slope          = cur_slope;
        e.intercept      = cur_icpt;
        e.r_squared      = cur_r2;
        e.fit_degenerate = cur_degen;
        e.sample_count   = 5'(n_valid);
        fit_exp_q.push_back(e);
    endtask

    // accept side: predictor fed on every accepted request and config write
    always @(posedge clk)
    begin
        cmd_took <= cmd_ch.valid && cmd_ch.ready;
        if (rst_n && cmd_ch.valid && cmd_ch.ready)
            predict_fit('{cmd_t'(cmd_ch.command), cmd_ch.sample_x, cmd_ch.sample_y});
        if (rst_n && cfg_ch.valid && cfg_ch.ready)
        begin
            max_diff = cfg_ch.data;
            n_cfg_writes++;
        end
    end

    // request driver: new request presented at the falling edge
    always @(negedge clk)
    begin
        fit_req_t r;
        if (rst_n && (!cmd_ch.valid || cmd_took))
        begin
            if (cmd_gap > 0)
            begin
                cmd_gap--;
                cmd_ch.valid <= 1'b0;
            end
            else if (req_q.size() != 0)
            begin
                // occasional burst of idle cycles before the next request
                if (!calm && $urandom_range(0, 5) == 0)
                begin
                    cmd_gap = $urandom_range(0, 4);
                    cmd_ch.valid <= 1'b0;
                end
                else
                begin
                    r = req_q.pop_front();
                    cmd_ch.valid    <= 1'b1;
                    cmd_ch.command  <= r.op;
                    cmd_ch.sample_x <= r.x;
                    cmd_ch.sample_y <= r.y;
                end
            end
            else
                cmd_ch.valid <= 1'b0;
        end
    end

    // result side back-pressure in random bursts
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (res_gap > 0)
            begin
                res_gap--;
                res_ch.ready <= 1'b0;
            end
            else if (!calm && $urandom_range(0, 5) == 0)
            begin
                res_gap = $urandom_range(0, 4);
                res_ch.ready <= 1'b0;
            end
            else
                res_ch.ready <= 1'b1;
        end
    end

    // result checker against the oldest expectation
    always @(posedge clk)
    begin
        fit_result_t e;
        if (rst_n && res_ch.valid && res_ch.ready)
        begin
            n_results++;
            if (fit_exp_q.size() == 0)
            begin
                $error("result with no request outstanding");
                n_errors++;
            end
            else
            begin
                e = fit_exp_q.pop_front();
                if (res_ch.slope !== e.slope)
                begin
                    $error("slope: expected %0d, got %0d", e.slope, res_ch.slope);
                    n_errors++;
                end
                if (res_ch.intercept !== e.intercept)
                begin
                    $error("intercept: expected %0d, got %0d", e.intercept, res_ch.intercept);
                    n_errors++;
                end
                if (res_ch.r_squared !== e.r_squared)
                begin
                    $error("r_squared: expected %0d, got %0d", e.r_squared, res_ch.r_squared);
                    n_errors++;
                end
                if (res_ch.best_y !== e.best_y)
                begin
                    $error("best_y: expected %0d, got %0d", e.best_y, res_ch.best_y);
                    n_errors++;
                end
                if (res_ch.from_fit !== e.from_fit)
                begin
                    $error("from_fit: expected %0d, got %0d", e.from_fit, res_ch.from_fit);
                    n_errors++;
                end
                if (res_ch.fit_degenerate !== e.fit_degenerate)
                begin
                    $error("fit_degenerate: expected %0d, got %0d",
                           e.fit_degenerate, res_ch.fit_degenerate);
                    n_errors++;
                end
                if (res_ch.sample_count !== e.sample_count)
                begin
                    $error("sample_count: expected %0d, got %0d",
                           e.sample_count, res_ch.sample_count);
                    n_errors++;
                end
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_CAP)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    task automatic push_req(cmd_t op, logic signed [31:0] x, logic signed [31:0] y);
        req_q.push_back('{op, x, y});
    endtask

    // wait until every request has been taken and answered, then let the core settle
    task automatic drain();
        while (req_q.size() != 0 || cmd_ch.valid || fit_exp_q.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
    endtask

    // hold the write until the edge that takes it, then drop valid
    task automatic write_max_diff(logic [31:0] v);
        @(negedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.data  <= v;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    // one random group: mostly well-formed fit sequences, some noise and oddities
    task automatic random_group(ref int made);
        int    kind, pts, nq;
        longint a, b, xv, yv, fv;
        kind = $urandom_range(0, 9);
        if (kind <= 6)
        begin
            if ($urandom_range(0, 2) == 0)
            begin
                push_req(CMD_CLEAR, $urandom, $urandom);
                made++;
            end
            a   = $signed($urandom_range(0, 1 << 19)) - (1 << 18);
            b   = $signed($urandom_range(0, 1 << 23)) - (1 << 22);
            // short windows mostly, sometimes past a full wrap
            pts = ($urandom_range(0, 4) == 0) ? $urandom_range(10, 20) : $urandom_range(1, 6);
            for (int i = 0; i < pts; i++)
            begin
                xv = $signed($urandom_range(0, 1 << 21)) - (1 << 20);
                yv = ((a * xv) >>> 16) + b + ($signed($urandom_range(0, 1 << 14)) - (1 << 13));
                push_req(CMD_ADD, 32'(xv), 32'(yv));
            end
            push_req(CMD_REFIT, $urandom, $urandom);
            made += pts + 1;
            nq = $urandom_range(1, 4);
            for (int i = 0; i < nq; i++)
            begin
                xv = $signed($urandom_range(0, 1 << 21)) - (1 << 20);
                fv = ((a * xv) >>> 16) + b;
                case ($urandom_range(0, 3))
                    0: yv = fv;
                    1: yv = fv + (fv >>> $urandom_range(1, 6));
                    2: yv = 0;
                    default: yv = fv + ($signed($urandom_range(0, 1 << 12)) - (1 << 11));
                endcase
                push_req(CMD_QUERY, 32'(xv), 32'(yv));
            end
            made += nq;
        end
        else if (kind <= 8)
        begin
            // full-range noise, any request
            for (int i = 0; i < 4; i++)
                push_req(cmd_t'($urandom_range(0, 3)), $urandom, $urandom);
            made += 4;
        end
        else
        begin
            // vertical line, then a refit and a query
            xv = $signed($urandom);
            for (int i = 0; i < 3; i++)
                push_req(CMD_ADD, 32'(xv), $urandom);
            push_req(CMD_REFIT, 0, 0);
            push_req(CMD_QUERY, $urandom, ($urandom_range(0, 1) == 0) ? 32'd0 : $urandom);
            made += 5;
        end
    endtask

    task automatic random_phase(int target);
        int made;
        made = 0;
        while (made < target)
            random_group(made);
        drain();
    endtask

    initial
    begin
        rst_n           = 1'b0;
        cmd_ch.valid    = 1'b0;
        cmd_ch.command  = CMD_ADD;
        cmd_ch.sample_x = '0;
        cmd_ch.sample_y = '0;
        res_ch.ready    = 1'b0;
        cfg_ch.valid    = 1'b0;
        cfg_ch.data     = '0;
        n_errors = 0; n_results = 0; n_from_fit = 0; n_degen_fits = 0;
        n_cfg_writes = 0; cycles = 0; cmd_took = 0; calm = 0; cmd_gap = 0; res_gap = 0;
        wr_slot = 0; n_valid = 0; cur_slope = '0; cur_icpt = '0; cur_r2 = '0;
        cur_degen = 1'b0; max_diff = MAX_DIFF_RST;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: empty-window cases, extremes, degenerate and flat fits, clear
        push_req(CMD_QUERY, 32'sh7fffffff, 32'd0);           // zero fit accepts y == 0
        push_req(CMD_QUERY, 32'sh80000000, 32'sd1);          // zero fit rejects anything else
        push_req(CMD_REFIT, 0, 0);                           // empty window: no change
        push_req(CMD_ADD, 32'sh80000000, 32'sh7fffffff);
        push_req(CMD_REFIT, 0, 0);                           // single sample: no change
        push_req(CMD_ADD, 32'sh7fffffff, 32'sh80000000);
        push_req(CMD_REFIT, 0, 0);                           // full-range line of slope minus one
        push_req(CMD_QUERY, 32'sh7fffffff, 32'sh7fffffff);
        push_req(CMD_QUERY, 32'sh80000000, 32'sh80000000);
        push_req(CMD_CLEAR, 32'hffffffff, 32'hffffffff);
        push_req(CMD_REFIT, 0, 0);                           // cleared: fit kept
        push_req(CMD_ADD, 32'sh00010000, 32'sh00020000);
        push_req(CMD_ADD, 32'sh00010000, 32'sh00050000);
        push_req(CMD_ADD, 32'sh00010000, 32'sh7fffffff);
        push_req(CMD_REFIT, 0, 0);                           // all x equal: degenerate
        push_req(CMD_QUERY, 32'sh00030000, 32'd0);
        push_req(CMD_CLEAR, 0, 0);
        push_req(CMD_ADD, 32'sh00010000, 32'sh00030000);
        push_req(CMD_ADD, 32'sh00020000, 32'sh00030000);
        push_req(CMD_ADD, 32'sh00030000, 32'sh00030000);
        push_req(CMD_REFIT, 0, 0);                           // flat y: r squared zero
        push_req(CMD_ADD, 32'sh00040000, 32'sh00070000);
        push_req(CMD_REFIT, 0, 0);
        push_req(CMD_QUERY, 32'sh00050000, 32'sh00060000);
        push_req(CMD_QUERY, 32'sh00050000, 32'sh00040000);
        drain();

        write_max_diff(32'd0);
        random_phase(160);
        write_max_diff(32'hffffffff);
        random_phase(160);
        write_max_diff(32'h00010000);
        random_phase(160);
        write_max_diff($urandom);
        random_phase(180);
        // last stretch without any idling
        write_max_diff(MAX_DIFF_RST);
        calm = 1'b1;
        random_phase(160);

        $display("covered %0d results, %0d fitted query answers, %0d degenerate refits,",
                 n_results, n_from_fit, n_degen_fits);
        $display("and %0d tolerance settings including zero and full scale", n_cfg_writes);
        if (n_errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
